// ----- rtl/core/frwsel_pkg.sv -----
package frwsel_pkg;

	localparam int OFFSET_W   = 32;
	localparam int LENGTH_W   = 16;
	localparam int SPEED_W    = 10;
	localparam int INDEX_W    = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int COUNT_W    = 6;

	// fragment end needs one bit more than an offset
	localparam int END_W  = OFFSET_W + 1;
	// index * speed + rounding bias
	localparam int PROD_W = INDEX_W + SPEED_W + 1;
	// (end - start) * 100
	localparam int DIST_W = END_W + 7;

	localparam logic [SPEED_W-1:0] SPEED_MIN   = 10'd2;
	localparam logic [SPEED_W-1:0] SPEED_MAX   = 10'd1000;
	localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd100;
	localparam logic [5:0]         ROUND_BIAS  = 6'd50;
	localparam logic [COUNT_W-1:0] MAX_RESULTS = 6'd52;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_POSITION = 8'd0,
		CFG_INITIAL_SPEED  = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic take;
		logic step;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic more;
		logic last;
		logic out_free;
	} dp_status_t;

	function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] v);
		logic [SPEED_W-1:0] r;
		r = v;
		if (v < SPEED_MIN) begin
			r = SPEED_MIN;
		end else if (v > SPEED_MAX) begin
			r = SPEED_MAX;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/frwsel_if.sv -----
interface frwsel_in_if;
	import frwsel_pkg::*;
	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] frag_offset;
	logic [LENGTH_W-1:0] frag_length;
	logic [SPEED_W-1:0]  new_speed;

	modport source (output valid, frag_offset, frag_length, new_speed, input ready);
	modport sink   (input valid, frag_offset, frag_length, new_speed, output ready);
endinterface

interface frwsel_out_if;
	import frwsel_pkg::*;
	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] copy_offset;
	logic [LENGTH_W-1:0] copy_length;
	logic                last_of_run;

	modport source (output valid, copy_offset, copy_length, last_of_run, input ready);
	modport sink   (input valid, copy_offset, copy_length, last_of_run, output ready);
endinterface

interface frwsel_cfg_if;
	import frwsel_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/frwsel_ctrl.sv -----
module frwsel_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  frwsel_pkg::dp_status_t  status,
	output frwsel_pkg::ctrl_cmd_t   cmd
);
	import frwsel_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EVAL   = 6'b000010,
		S_TEST   = 6'b000100,
		S_STEP   = 6'b001000,
		S_EVAL_N = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_TEST;
			end
			S_TEST: begin
				// fragment ends at or before the target: skipped, no item out
				if (status.more) begin
					cmd.take = 1'b1;
					state_d  = S_STEP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_EVAL_N;
			end
			S_EVAL_N: begin
				cmd.eval = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = status.last ? S_IDLE : S_STEP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/frwsel_dp.sv -----
module frwsel_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frwsel_pkg::ctrl_cmd_t             cmd,
	output frwsel_pkg::dp_status_t            status,
	input  logic [frwsel_pkg::OFFSET_W-1:0]   frag_offset,
	input  logic [frwsel_pkg::LENGTH_W-1:0]   frag_length,
	input  logic [frwsel_pkg::SPEED_W-1:0]    new_speed,
	input  logic                              cfg_wr,
	input  logic [frwsel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frwsel_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [frwsel_pkg::OFFSET_W-1:0]   copy_offset,
	output logic [frwsel_pkg::LENGTH_W-1:0]   copy_length,
	output logic                              last_of_run
);
	import frwsel_pkg::*;

	// descriptor being worked on
	logic [OFFSET_W-1:0] off_q;
	logic [LENGTH_W-1:0] len_q;
	logic [SPEED_W-1:0]  spd_q;
	logic [END_W-1:0]    end_q;

	// configuration
	logic [OFFSET_W-1:0] start_pos_q;
	logic [SPEED_W-1:0]  init_spd_q;

	// warp state
	logic [OFFSET_W-1:0] warp_start_q;
	logic [INDEX_W-1:0]  warp_index_q;
	logic [SPEED_W-1:0]  cur_spd_q;
	logic                started_q;

	logic [PROD_W-1:0]   prod_q;
	logic [DIST_W-1:0]   dist_q;
	logic                ahead_q;
	logic [COUNT_W-1:0]  cnt_q;

	logic                out_valid_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic [LENGTH_W-1:0] out_len_q;
	logic                out_last_q;

	logic [END_W-1:0]            diff;
	logic [DIST_W-1:0]           diff_w;
	logic [INDEX_W+SPEED_W-1:0]  mul;
	logic                        more;

	// target < end  <=>  end > start && idx*spd + 50 < 100*(end - start)
	assign diff   = end_q - {1'b0, warp_start_q};
	assign diff_w = DIST_W'(diff);
	assign mul    = warp_index_q * cur_spd_q;
	assign more   = ahead_q && (prod_q < PROD_W'(dist_q));

	assign status.more     = more;
	assign status.last     = !more || (cnt_q == MAX_RESULTS);
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q <= frag_offset;
			len_q <= frag_length;
			spd_q <= sat_speed(new_speed);
			end_q <= {1'b0, frag_offset} + END_W'(frag_length);
		end
		if (cmd.eval) begin
			prod_q  <= PROD_W'(mul) + PROD_W'(ROUND_BIAS);
			dist_q  <= (diff_w << 6) + (diff_w << 5) + (diff_w << 2);
			ahead_q <= end_q > {1'b0, warp_start_q};
		end
		if (cmd.emit) begin
			out_off_q  <= off_q;
			out_len_q  <= len_q;
			out_last_q <= status.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pos_q  <= '0;
			init_spd_q   <= SPEED_RESET;
			warp_start_q <= '0;
			warp_index_q <= '0;
			cur_spd_q    <= SPEED_RESET;
			started_q    <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_START_POSITION: begin
						start_pos_q  <= cfg_data;
						warp_start_q <= cfg_data;
						warp_index_q <= '0;
						cur_spd_q    <= sat_speed(init_spd_q);
						started_q    <= 1'b0;
					end
					CFG_INITIAL_SPEED: begin
						init_spd_q   <= cfg_data[SPEED_W-1:0];
						warp_start_q <= start_pos_q;
						warp_index_q <= '0;
						cur_spd_q    <= sat_speed(cfg_data[SPEED_W-1:0]);
						started_q    <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end
			// first match keeps the current speed; later ones may rebase
			if (cmd.take) begin
				if (!started_q) begin
					started_q <= 1'b1;
				end else if (spd_q != cur_spd_q) begin
					warp_start_q <= off_q;
					warp_index_q <= '0;
					cur_spd_q    <= spd_q;
				end
			end
			if (cmd.step) begin
				warp_index_q <= warp_index_q + INDEX_W'(len_q);
				cnt_q        <= cnt_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign copy_offset = out_off_q;
	assign copy_length = out_len_q;
	assign last_of_run = out_last_q;

endmodule

// ----- rtl/core/fragment_rate_warp_selector_top.sv -----
// Flow: a descriptor is accepted in idle, then evaluated and tested against the target;
// one descriptor at a time. Each copy item then passes step, multiply and compare and
//   waits in emit for a free output register; all share the single index*speed multiplier.
// A skipped descriptor returns to idle after the test. The output register frees the next accept.
// Reset (arst_n low): start 0, speed 100, index 0, not started, no item pending.
module fragment_rate_warp_selector_top (
	input logic         clk,
	input logic         arst_n,
	frwsel_in_if.sink   frag,
	frwsel_out_if.source copy,
	frwsel_cfg_if.sink  cfg
);
	import frwsel_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       in_ready;

	assign frag.ready = in_ready;
	assign cfg.ready  = 1'b1;

	frwsel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frag.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	frwsel_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.frag_offset (frag.frag_offset),
		.frag_length (frag.frag_length),
		.new_speed   (frag.new_speed),
		.cfg_wr      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.out_valid   (copy.valid),
		.out_ready   (copy.ready),
		.copy_offset (copy.copy_offset),
		.copy_length (copy.copy_length),
		.last_of_run (copy.last_of_run)
	);

endmodule

// ----- rtl/core/frwsel_checker.sv -----
module frwsel_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            frag_valid,
	input logic                            frag_ready,
	input logic                            copy_valid,
	input logic                            copy_ready,
	input logic [frwsel_pkg::OFFSET_W-1:0] copy_offset,
	input logic [frwsel_pkg::LENGTH_W-1:0] copy_length,
	input logic                            last_of_run
);
	import frwsel_pkg::*;

	logic frag_acc;
	assign frag_acc = frag_valid && frag_ready;

	// stalled item holds
	a_copy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		copy_valid && !copy_ready |=> copy_valid && $stable(copy_offset)
			&& $stable(copy_length) && $stable(last_of_run))
		else $error("copy item changed while stalled");

	// one descriptor at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		frag_acc |=> !frag_ready)
		else $error("descriptor accepted while previous one in work");

	// a new item cannot come out straight after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(copy_valid) |-> !$past(frag_acc, 1) && !$past(frag_acc, 2))
		else $error("copy item too soon after accept");

endmodule

bind fragment_rate_warp_selector_top frwsel_checker u_frwsel_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frag_valid  (frag.valid),
	.frag_ready  (frag.ready),
	.copy_valid  (copy.valid),
	.copy_ready  (copy.ready),
	.copy_offset (copy.copy_offset),
	.copy_length (copy.copy_length),
	.last_of_run (copy.last_of_run)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import frwsel_pkg::*;

	localparam int PREDICTED      = -1;
	localparam int N_DIRECTED     = 14;
	localparam int N_PHASES       = 6;
	localparam int PHASE_ITEMS    = 40;
	localparam int WRAP_ITEMS     = 8;
	localparam int SETTLE_CYCLES  = 16;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTED    = 30;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFE;
	// slow enough that index*2/100 never reaches it before the index wraps
	localparam logic [OFFSET_W-1:0]  WRAP_OFFSET  = 32'd86_000_000;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
		logic                last_of_run;
	} copy_cmd_t;

	typedef struct {
		logic [OFFSET_W-1:0] off;
		logic [LENGTH_W-1:0] len;
		logic [SPEED_W-1:0]  rate;
		int                  typed;  // copies known up front, or PREDICTED
	} frag_row_t;

	frag_row_t directed_rows [N_DIRECTED] = '{
		'{32'd0,           16'd0,    10'd100,  0},          // zero length
		'{32'd0,           16'd10,   10'd100,  1},          // first match keeps speed
		'{32'd0,           16'd10,   10'd100,  0},          // ends exactly at target
		'{32'd10,          16'd20,   10'd100,  PREDICTED},
		'{32'd30,          16'd1,    10'd0,    PREDICTED},  // clamps up to 2
		'{32'd31,          16'd200,  10'd1023, PREDICTED},  // clamps down to 1000
		'{32'd231,         16'd300,  10'd1000, PREDICTED},
		'{32'd531,         16'hFFFF, 10'd700,  PREDICTED},
		'{32'hF000_0000,   16'd100,  10'd700,  PREDICTED},  // far ahead: repeat cap
		'{32'hFFFF_FFFF,   16'hFFFF, 10'd700,  PREDICTED},  // end past 2^32
		'{32'h5555_5555,   16'hAAAA, 10'h2AA,  PREDICTED},
		'{32'hAAAA_AAAA,   16'h5555, 10'h155,  PREDICTED},
		'{32'd100,         16'd50,   10'd2,    PREDICTED},
		'{32'd0,           16'd1,    10'd2,    PREDICTED}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #10 clk = ~clk;

	frwsel_in_if  frag_bus ();
	frwsel_out_if copy_bus ();
	frwsel_cfg_if cfg_bus ();

	fragment_rate_warp_selector_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frag   (frag_bus),
		.copy   (copy_bus),
		.cfg    (cfg_bus)
	);

	// warp state as the block should hold it
	logic [OFFSET_W-1:0] cfg_start;
	logic [SPEED_W-1:0]  cfg_rate_raw;
	logic [OFFSET_W-1:0] warp_origin;
	logic [INDEX_W-1:0]  played_idx;
	logic [SPEED_W-1:0]  cur_rate;
	logic                locked;

	copy_cmd_t planned[$];
	copy_cmd_t copy_q[$];

	int mismatches = 0;
	int quiet_cycles = 0;
	bit src_idle_on = 1'b0;
	bit sink_idle_on = 1'b0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int stall_left = 0;

	function automatic logic [SPEED_W-1:0] clamp_rate(input logic [SPEED_W-1:0] r);
		return (r < 10'd2) ? 10'd2 : ((r > 10'd1000) ? 10'd1000 : r);
	endfunction

	function automatic void restart_warp();
		warp_origin = cfg_start;
		played_idx  = '0;
		cur_rate    = clamp_rate(cfg_rate_raw);
		locked      = 1'b0;
	endfunction

	// rounded, never wraps: origin + (index*rate + 50)/100
	function automatic logic [63:0] warp_target();
		logic [63:0] scaled;
		scaled = 64'(played_idx) * 64'(cur_rate) + 64'd50;
		return 64'(warp_origin) + scaled / 64'd100;
	endfunction

	function automatic void plan_copies(input logic [OFFSET_W-1:0] off,
			input logic [LENGTH_W-1:0] len, input logic [SPEED_W-1:0] rate_raw);
		logic [SPEED_W-1:0] rate;
		logic [63:0]        frag_end;
		copy_cmd_t          cmd;
		int                 n;
		planned.delete();
		rate = clamp_rate(rate_raw);
		frag_end = 64'(off) + 64'(len);
		if (frag_end <= warp_target()) return;
		if (!locked) begin
			locked = 1'b1;
		end else if (rate != cur_rate) begin
			warp_origin = off;
			played_idx  = '0;
			cur_rate    = rate;
		end
		n = 0;
		do begin
			n++;
			played_idx = played_idx + 32'(len);
			cmd.offset = off;
			cmd.length = len;
			cmd.last_of_run = !(warp_target() < frag_end) || (n >= int'(MAX_RESULTS));
			planned.push_back(cmd);
		end while (!cmd.last_of_run);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED) $display("mismatch: %s", what);
		mismatches++;
	endtask

	task automatic send_frag(input logic [OFFSET_W-1:0] off, input logic [LENGTH_W-1:0] len,
			input logic [SPEED_W-1:0] rate, input int typed);
		copy_cmd_t cmd;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			frag_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		frag_bus.valid       <= 1'b1;
		frag_bus.frag_offset <= off;
		frag_bus.frag_length <= len;
		frag_bus.new_speed   <= rate;
		do @(posedge clk); while (!frag_bus.ready);
		plan_copies(off, len, rate);
		if (typed == PREDICTED) begin
			foreach (planned[k]) copy_q.push_back(planned[k]);
		end else begin
			for (int k = 0; k < typed; k++) begin
				cmd.offset = off;
				cmd.length = len;
				cmd.last_of_run = (k == typed - 1);
				copy_q.push_back(cmd);
			end
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input bit keep_valid);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		if (!keep_valid) cfg_bus.valid <= 1'b0;
		if (idx == CFG_START_POSITION) begin
			cfg_start = data;
			restart_warp();
		end else if (idx == CFG_INITIAL_SPEED) begin
			cfg_rate_raw = data[SPEED_W-1:0];
			restart_warp();
		end
	endtask

	task automatic wait_drained();
		frag_bus.valid <= 1'b0;
		do @(posedge clk); while (copy_q.size() != 0);
	endtask

	// skipped descriptors leave no trace in the queue, so give them time to clear
	task automatic settle_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly contiguous fragments at a steady rate, some noise
	task automatic random_frag(inout logic [32:0] cursor, inout logic [SPEED_W-1:0] rate_req);
		logic [OFFSET_W-1:0] off;
		logic [LENGTH_W-1:0] len;
		int                  pick;
		if ($urandom_range(0, 9) < 8) begin
			pick = $urandom_range(0, 31);
			if (pick == 0)      len = '0;
			else if (pick == 1) len = 16'hFFFF;
			else if (pick == 2) len = 16'd1;
			else if (pick < 6)  len = LENGTH_W'($urandom_range(1, 65535));
			else                len = LENGTH_W'($urandom_range(1, 400));
			off = cursor[OFFSET_W-1:0];
			cursor = cursor + 33'(len);
			if (cursor[32]) cursor = {1'b0, $urandom()};
			if ($urandom_range(0, 9) == 0) rate_req = SPEED_W'($urandom_range(0, 1023));
			send_frag(off, len, rate_req, PREDICTED);
		end else begin
			send_frag($urandom(), LENGTH_W'($urandom_range(0, 65535)),
				SPEED_W'($urandom_range(0, 1023)), PREDICTED);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			copy_bus.ready <= 1'b0;
		end else begin
			if (holds_served != holds_asked) begin
				holds_served = holds_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				copy_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				copy_bus.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = int'($urandom_range(0, 10));
				copy_bus.ready <= 1'b0;
			end else begin
				copy_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_copy
		copy_cmd_t want;
		if (arst_n && copy_bus.valid && copy_bus.ready) begin
			if (copy_q.size() == 0) begin
				report_mismatch($sformatf("unexpected copy item offset %h length %0d",
					copy_bus.copy_offset, copy_bus.copy_length));
			end else begin
				want = copy_q.pop_front();
				if (copy_bus.copy_offset !== want.offset)
					report_mismatch($sformatf("copy_offset %h, want %h",
						copy_bus.copy_offset, want.offset));
				if (copy_bus.copy_length !== want.length)
					report_mismatch($sformatf("copy_length %0d, want %0d at offset %h",
						copy_bus.copy_length, want.length, want.offset));
				if (copy_bus.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %b, want %b at offset %h",
						copy_bus.last_of_run, want.last_of_run, want.offset));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((frag_bus.valid && frag_bus.ready) || (copy_bus.valid && copy_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[fragment_rate_warp_selector_top] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [32:0]        cursor;
		logic [SPEED_W-1:0] rate_req;
		frag_bus.valid       = 1'b0;
		frag_bus.frag_offset = '0;
		frag_bus.frag_length = '0;
		frag_bus.new_speed   = SPEED_RESET;
		cfg_bus.valid        = 1'b0;
		cfg_bus.index        = CFG_START_POSITION;
		cfg_bus.data         = '0;
		cfg_start    = '0;
		cfg_rate_raw = SPEED_RESET;
		restart_warp();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: start 0, rate 100
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		foreach (directed_rows[r])
			send_frag(directed_rows[r].off, directed_rows[r].len, directed_rows[r].rate,
				directed_rows[r].typed);

		// short run of capped repeats at rate 2
		settle_idle();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		cfg_write(CFG_START_POSITION, 32'd0, 1'b1);
		cfg_write(CFG_INITIAL_SPEED, 32'd2, 1'b0);
		repeat (WRAP_ITEMS) send_frag(WRAP_OFFSET, 16'hFFFF, 10'd2, PREDICTED);

		cursor = '0;
		rate_req = SPEED_RESET;
		for (int phase = 0; phase < N_PHASES; phase++) begin
			settle_idle();
			case (phase)
				0: begin
					cfg_write(CFG_START_POSITION, 32'd0, 1'b1);
					cfg_write(CFG_INITIAL_SPEED, 32'd100, 1'b0);
				end
				1: begin
					cfg_write(CFG_START_POSITION, 32'hFFFF_FFFF, 1'b1);
					cfg_write(CFG_INITIAL_SPEED, 32'hFFFF_FFFF, 1'b0);
				end
				2: begin
					cfg_write(CFG_START_POSITION, $urandom(), 1'b1);
					cfg_write(CFG_INITIAL_SPEED, 32'hFFFF_FC00, 1'b0);
				end
				3: cfg_write(CFG_UNMAPPED, $urandom(), 1'b0);  // ignored, no restart
				4: cfg_write(CFG_INITIAL_SPEED, 32'd1000, 1'b0);
				default: begin
					cfg_write(CFG_START_POSITION, $urandom(), 1'b1);
					cfg_write(CFG_INITIAL_SPEED, $urandom_range(2, 1000), 1'b0);
				end
			endcase
			if (phase != 3) begin
				cursor = {1'b0, cfg_start};
				rate_req = cfg_rate_raw;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				src_idle_on  = (phase != N_PHASES - 1) && (i % 20 < 14);
				sink_idle_on = src_idle_on;
				// receiver backs off while descriptors keep coming
				if (phase == 2 && i == 10) holds_asked++;
				if (phase == 3 && i == 20) wait_drained();
				random_frag(cursor, rate_req);
			end
		end

		settle_idle();
		if (mismatches == 0) begin
			$display("[fragment_rate_warp_selector_top] OK");
		end else begin
			$display("[fragment_rate_warp_selector_top] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/frwsel_pkg.sv
rtl/core/frwsel_if.sv
rtl/core/frwsel_ctrl.sv
rtl/core/frwsel_dp.sv
rtl/core/fragment_rate_warp_selector_top.sv
rtl/core/frwsel_checker.sv
test/testbench.sv
